// ----- src/ttlb_pkg.sv -----
// ttlb_pkg: shared constants, types and command/status structs for the tagged tlb
// no dependencies
package ttlb_pkg;
    localparam int DEPTH      = 16;
    localparam int PID_BITS   = 16;
    localparam int PAGE_BITS  = 20;
    localparam int FRAME_BITS = 20;
    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = 32;

    typedef logic [IDX_BITS-1:0] t_idx;

    typedef enum logic [2:0] {
        OP_LOOKUP    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_DROP      = 3'd2,
        OP_FLUSH_ALL = 3'd3,
        OP_FLUSH_PID = 3'd4
    } t_op;

    localparam logic [0:0] REG_POLICY = 1'b0;
    localparam logic [0:0] REG_SIZE   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input item and compare
        logic execute;   // apply the operation, form the result
        logic cfg_wr;    // configuration write
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;
    } t_stat;
endpackage

// ----- src/ttlb_ctrl.sv -----
// ttlb_ctrl: two-step sequencer, capture then execute
// depends on ttlb_pkg
module ttlb_ctrl import ttlb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_cfg_valid,
    input  t_stat i_stat,
    output logic  o_busy,
    output logic  o_cfg_ready,
    output t_cmd  o_cmd
);
    typedef enum logic [0:0] {S_IDLE, S_EXEC} t_state;
    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_start) r_state <= S_EXEC;
                S_EXEC:  if (i_stat.done) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.execute = (r_state == S_EXEC);
    assign o_cmd.cfg_wr  = i_cfg_valid && o_cfg_ready;
endmodule

// ----- src/ttlb_dp.sv -----
// ttlb_dp: tag store, replacement ranks, counters and result register
// depends on ttlb_pkg
module ttlb_dp import ttlb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [2:0]            i_op,
    input  logic [PID_BITS-1:0]   i_pid,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [FRAME_BITS-1:0] i_frame,
    input  logic [0:0]            i_cfg_index,
    input  logic                  i_cfg_hi,
    input  logic [4:0]            i_cfg_data,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic [19:0]           o_frame_out,
    output logic                  o_evicted,
    output logic [3:0]            o_slot,
    output logic [CNT_W-1:0]      o_hits_total,
    output logic [CNT_W-1:0]      o_misses_total
);
    localparam int SZ_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0]      r_valid;
    logic [PID_BITS-1:0]   r_pid_tag   [DEPTH];
    logic [PAGE_BITS-1:0]  r_page_tag  [DEPTH];
    logic [FRAME_BITS-1:0] r_frame_mem [DEPTH];
    t_idx                  r_rank      [DEPTH];
    logic                  r_policy;
    logic [SZ_W-1:0]       r_size;
    logic [CNT_W-1:0]      r_hits, r_misses;

    // captured item and match vectors
    logic [2:0]            r_op;
    logic [PID_BITS-1:0]   r_pid;
    logic [PAGE_BITS-1:0]  r_page;
    logic [FRAME_BITS-1:0] r_frame;
    logic [DEPTH-1:0]      r_full_m, r_pid_m, r_active;

    // compare stage
    logic [DEPTH-1:0] n_full_m, n_pid_m, n_active;
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            n_active[j] = (SZ_W'(j) < r_size);
            n_pid_m[j]  = r_valid[j] && (r_pid_tag[j] == i_pid);
            n_full_m[j] = n_pid_m[j] && (r_page_tag[j] == i_page) && n_active[j];
        end
    end

    // execute stage decisions
    logic [DEPTH-1:0] free_v, oldest_v, lru_hit_v;
    logic             any_hit, any_free;
    t_idx             hi_hit, lo_hit, lo_free, lo_old;
    logic [SZ_W-1:0]  cnt;
    always_comb begin
        any_hit = 1'b0; any_free = 1'b0;
        hi_hit = '0; lo_hit = '0; lo_free = '0; lo_old = '0;
        cnt = '0;
        for (int j = 0; j < DEPTH; j++) begin
            free_v[j]   = !r_valid[j] && r_active[j];
            oldest_v[j] = r_valid[j] && r_active[j] && (r_rank[j] == '0);
            cnt = cnt + SZ_W'(r_valid[j]);
            if (r_full_m[j]) begin
                hi_hit = t_idx'(j);
            end
        end
        for (int j = DEPTH - 1; j >= 0; j--) begin
            if (r_full_m[j]) begin
                lo_hit = t_idx'(j);
                any_hit = 1'b1;
            end
            if (free_v[j]) begin
                lo_free = t_idx'(j);
                any_free = 1'b1;
            end
            if (oldest_v[j]) lo_old = t_idx'(j);
        end
        lru_hit_v = r_full_m;
    end

    // entries removed by a drop or flush, for rank compaction
    logic [DEPTH-1:0] kill_v;
    logic [DEPTH-1:0] set_v;
    logic             do_newest;
    t_idx             newest_idx;
    always_comb begin
        kill_v = '0;
        set_v = '0;
        do_newest = 1'b0;
        newest_idx = '0;
        case (r_op)
            OP_LOOKUP: begin
                do_newest  = any_hit && r_policy;
                newest_idx = hi_hit;
            end
            OP_INSERT: begin
                do_newest  = !any_free;
                newest_idx = lo_old;
                if (any_free) set_v[lo_free] = 1'b1;
            end
            OP_DROP:      if (any_hit) kill_v[lo_hit] = 1'b1;
            OP_FLUSH_ALL: kill_v = r_valid;
            OP_FLUSH_PID: kill_v = r_pid_m;
            default: ;
        endcase
    end

    // new ranks: compaction below survivors, or refresh of a group
    t_idx n_rank [DEPTH];
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            logic [SZ_W-1:0] below;
            logic [SZ_W-1:0] nmov;
            below = '0;
            nmov  = '0;
            for (int k = 0; k < DEPTH; k++) begin
                if (kill_v[k] && r_valid[k] && r_rank[k] < r_rank[j]) below = below + 1'b1;
            end
            n_rank[j] = r_rank[j] - t_idx'(below);
            if (do_newest) begin
                // under lru every matching entry moves up, ascending index;
                // equivalent: non-moved entries drop by moved ones below them,
                // moved ones take the top places in index order
                if (r_op == OP_LOOKUP) begin
                    for (int k = 0; k < DEPTH; k++) begin
                        if (lru_hit_v[k] && r_rank[k] < r_rank[j]) nmov = nmov + 1'b1;
                    end
                    if (!lru_hit_v[j]) begin
                        n_rank[j] = r_rank[j] - t_idx'(nmov);
                    end else begin
                        nmov = '0;
                        for (int k = 0; k < DEPTH; k++) begin
                            if (lru_hit_v[k] && k > j) nmov = nmov + 1'b1;
                        end
                        n_rank[j] = t_idx'(cnt - 1'b1 - nmov);
                    end
                end else begin
                    if (t_idx'(j) == newest_idx) n_rank[j] = t_idx'(cnt - 1'b1);
                    else if (r_valid[j])         n_rank[j] = r_rank[j] - 1'b1;
                end
            end
            if (kill_v[j]) n_rank[j] = '0;
            // new entry rank on a free slot is the current valid count
            if (set_v[j]) n_rank[j] = t_idx'(cnt);
        end
    end

    // resize compaction
    logic [SZ_W-1:0] new_size;
    logic [DEPTH-1:0] cut_v;
    t_idx cut_rank [DEPTH];
    always_comb begin
        new_size = (i_cfg_data == '0) ? SZ_W'(1)
                 : ({1'b0, i_cfg_data} > 6'(DEPTH)) ? SZ_W'(DEPTH)
                 : SZ_W'(i_cfg_data);
        if (i_cfg_hi) new_size = SZ_W'(1) > new_size ? SZ_W'(1) : new_size;
        for (int j = 0; j < DEPTH; j++) cut_v[j] = r_valid[j] && (SZ_W'(j) >= new_size);
        for (int j = 0; j < DEPTH; j++) begin
            logic [SZ_W-1:0] below;
            below = '0;
            for (int k = 0; k < DEPTH; k++) begin
                if (cut_v[k] && r_rank[k] < r_rank[j]) below = below + 1'b1;
            end
            cut_rank[j] = cut_v[j] ? '0 : r_rank[j] - t_idx'(below);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_policy <= 1'b0;
            r_size   <= SZ_W'(DEPTH);
            r_hits   <= '0;
            r_misses <= '0;
            o_valid  <= 1'b0;
            for (int j = 0; j < DEPTH; j++) r_rank[j] <= '0;
        end else begin
            o_valid <= i_cmd.execute;
            if (i_cmd.cfg_wr) begin
                if (i_cfg_index == REG_POLICY && !i_cfg_hi) begin
                    r_policy <= i_cfg_data[0];
                end else if (i_cfg_index == REG_SIZE && !i_cfg_hi) begin
                    r_size  <= new_size;
                    r_valid <= r_valid & ~cut_v;
                    for (int j = 0; j < DEPTH; j++) r_rank[j] <= cut_rank[j];
                end
            end
            if (i_cmd.execute) begin
                for (int j = 0; j < DEPTH; j++) r_rank[j] <= n_rank[j];
                r_valid <= (r_valid & ~kill_v) | set_v;
                if (r_op == OP_LOOKUP) begin
                    if (any_hit) begin
                        if (r_hits != '1) r_hits <= r_hits + 1'b1;
                    end else if (r_misses != '1) begin
                        r_misses <= r_misses + 1'b1;
                    end
                end
            end
        end
    end

    // result fields
    t_idx ins_idx;
    logic        n_hit;
    logic [19:0] n_frame_out;
    logic        n_evicted;
    logic [3:0]  n_slot;
    assign ins_idx = any_free ? lo_free : lo_old;
    always_comb begin
        n_hit       = 1'b0;
        n_frame_out = '0;
        n_evicted   = 1'b0;
        n_slot      = '0;
        case (r_op)
            OP_LOOKUP: if (any_hit) begin
                n_hit       = 1'b1;
                n_frame_out = 20'(r_frame_mem[hi_hit]);
                n_slot      = 4'(hi_hit);
            end
            OP_INSERT: begin
                n_evicted = !any_free;
                n_slot    = 4'(ins_idx);
            end
            OP_DROP: if (any_hit) n_slot = 4'(lo_hit);
            default: ;
        endcase
    end

    // payload: captured item, stores, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_pid    <= i_pid;
            r_page   <= i_page;
            r_frame  <= i_frame;
            r_full_m <= n_full_m;
            r_pid_m  <= n_pid_m;
            r_active <= n_active;
        end
        if (i_cmd.execute) begin
            o_hit       <= n_hit;
            o_frame_out <= n_frame_out;
            o_evicted   <= n_evicted;
            o_slot      <= n_slot;
            if (r_op == OP_INSERT) begin
                r_pid_tag[ins_idx]   <= r_pid;
                r_page_tag[ins_idx]  <= r_page;
                r_frame_mem[ins_idx] <= r_frame;
            end
        end
    end

    assign o_hits_total   = r_hits;
    assign o_misses_total = r_misses;
    assign o_stat.done    = i_cmd.execute;
endmodule

// ----- src/tagged_tlb_fifo_lru_unit.sv -----
// tagged_tlb_fifo_lru_unit: top level, sequencer plus datapath
// depends on ttlb_pkg, ttlb_ctrl, ttlb_dp
//
// Fully associative TLB tagged by pid and page, with FIFO or LRU replacement.
// Each accepted command is captured with its tag compare, then applied in
// the execute step; o_valid is registered from that step and is high for a
// single cycle with the one result. busy is high in the execute step, so a
// new command starts only after the last is applied. Results cannot be held
// off. Configuration writes are taken while idle and no start is pending.
module tagged_tlb_fifo_lru_unit import ttlb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_op,
    input  logic [PID_BITS-1:0]   i_pid,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [FRAME_BITS-1:0] i_frame,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic [19:0]           o_frame_out,
    output logic                  o_evicted,
    output logic [3:0]            o_slot,
    output logic [31:0]           o_hits_total,
    output logic [31:0]           o_misses_total
);
    t_cmd  cmd;
    t_stat stat;
    logic  cfg_hi;

    // any index above one is ignored; size takes the low five data bits
    assign cfg_hi = (i_cfg_index[7:1] != '0);

    ttlb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_cfg_valid, .i_stat(stat),
        .o_busy(busy), .o_cfg_ready, .o_cmd(cmd)
    );

    ttlb_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_op, .i_pid, .i_page, .i_frame,
        .i_cfg_index(i_cfg_index[0:0]),
        .i_cfg_hi(cfg_hi),
        .i_cfg_data(i_cfg_data[4:0]),
        .o_valid, .o_hit, .o_frame_out, .o_evicted, .o_slot,
        .o_hits_total, .o_misses_total
    );
endmodule

// ----- bench/tagged_tlb_fifo_lru_unit_chk.sv -----
// tagged_tlb_fifo_lru_unit_chk: watches command, config and result channels of the tlb,
// keeps its own copy of the tag store and replacement order, compares every result
// depends on ttlb_pkg
`timescale 1ns / 100ps

module tagged_tlb_fifo_lru_unit_chk import ttlb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [2:0]            i_op,
    input  logic [PID_BITS-1:0]   i_pid,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  logic [FRAME_BITS-1:0] i_frame,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  o_valid,
    input  logic                  o_hit,
    input  logic [19:0]           o_frame_out,
    input  logic                  o_evicted,
    input  logic [3:0]            o_slot,
    input  logic [31:0]           o_hits_total,
    input  logic [31:0]           o_misses_total,
    output int                    o_fail_count,
    output int                    o_pending
);
    typedef struct packed {
        logic        hit;
        logic [19:0] frame;
        logic        evicted;
        logic [3:0]  slot;
        logic [31:0] hits;
        logic [31:0] misses;
    } t_xlat;

    logic                  tag_valid [DEPTH];
    logic [PID_BITS-1:0]   tag_pid   [DEPTH];
    logic [PAGE_BITS-1:0]  tag_page  [DEPTH];
    logic [FRAME_BITS-1:0] tag_frame [DEPTH];
    logic [3:0]            age       [DEPTH];
    logic [31:0]           hit_cnt, miss_cnt;
    logic                  lru_mode;
    logic [4:0]            active_n;
    t_xlat                 xlat_q[$];

    assign o_pending = xlat_q.size();

    function automatic logic [4:0] live_count();
        logic [4:0] n;
        n = 0;
        for (int j = 0; j < DEPTH; j++) if (tag_valid[j]) n++;
        return n;
    endfunction

    // entries younger than i move down one place
    function automatic void close_gap(int i);
        for (int j = 0; j < DEPTH; j++)
            if (j != i && tag_valid[j] && age[j] > age[i]) age[j]--;
    endfunction

    function automatic void kill_entry(int i);
        if (tag_valid[i]) begin
            close_gap(i);
            tag_valid[i] = 1'b0;
            age[i] = 0;
        end
    endfunction

    function automatic void promote(int i);
        logic [4:0] n;
        n = live_count();
        close_gap(i);
        age[i] = 4'(n - 1);
    endfunction

    function automatic void apply_reg(logic [7:0] idx, logic [31:0] data);
        logic [4:0] v;
        if (idx == 8'(REG_POLICY)) begin
            lru_mode = data[0];
        end else if (idx == 8'(REG_SIZE)) begin
            v = data[4:0];
            if (v < 1) v = 1;
            if (v > DEPTH) v = DEPTH;
            active_n = v;
            for (int j = v; j < DEPTH; j++) kill_entry(j);
        end
    endfunction

    function automatic t_xlat translate(logic [2:0] op, logic [PID_BITS-1:0] pid,
                                        logic [PAGE_BITS-1:0] page,
                                        logic [FRAME_BITS-1:0] frame);
        t_xlat r;
        int    tgt;
        r = '0;
        case (op)
            OP_LOOKUP: begin
                for (int j = 0; j < active_n; j++) begin
                    if (tag_valid[j] && tag_pid[j] == pid && tag_page[j] == page) begin
                        r.hit = 1'b1;
                        r.frame = tag_frame[j];
                        r.slot = 4'(j);
                        if (lru_mode) promote(j);
                    end
                end
                if (r.hit) begin
                    if (hit_cnt != '1) hit_cnt++;
                end else begin
                    if (miss_cnt != '1) miss_cnt++;
                end
            end
            OP_INSERT: begin
                tgt = -1;
                for (int j = 0; j < active_n; j++)
                    if (tgt < 0 && !tag_valid[j]) tgt = j;
                if (tgt >= 0) begin
                    age[tgt] = 4'(live_count());
                    tag_valid[tgt] = 1'b1;
                end else begin
                    tgt = 0;
                    for (int j = active_n - 1; j >= 0; j--)
                        if (tag_valid[j] && age[j] == 0) tgt = j;
                    promote(tgt);
                    r.evicted = 1'b1;
                end
                tag_pid[tgt] = pid;
                tag_page[tgt] = page;
                tag_frame[tgt] = frame;
                r.slot = 4'(tgt);
            end
            OP_DROP: begin
                tgt = -1;
                for (int j = 0; j < active_n; j++)
                    if (tgt < 0 && tag_valid[j] && tag_pid[j] == pid && tag_page[j] == page)
                        tgt = j;
                if (tgt >= 0) begin
                    kill_entry(tgt);
                    r.slot = 4'(tgt);
                end
            end
            OP_FLUSH_ALL: begin
                for (int j = 0; j < DEPTH; j++) begin
                    tag_valid[j] = 1'b0;
                    age[j] = 0;
                end
            end
            OP_FLUSH_PID: begin
                for (int j = 0; j < DEPTH; j++)
                    if (tag_valid[j] && tag_pid[j] == pid) kill_entry(j);
            end
            default: ;
        endcase
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_xlat want;
        if (!i_rst_n) begin
            for (int j = 0; j < DEPTH; j++) begin
                tag_valid[j] = 1'b0;
                tag_pid[j] = '0;
                tag_page[j] = '0;
                tag_frame[j] = '0;
                age[j] = 0;
            end
            hit_cnt = 0;
            miss_cnt = 0;
            lru_mode = 1'b0;
            active_n = DEPTH;
            xlat_q.delete();
        end else begin
            if (o_valid) begin
                if (xlat_q.size() == 0) begin
                    $display("%0t: result with nothing expected: hit %0d frame %h slot %0d",
                             $time, o_hit, o_frame_out, o_slot);
                    o_fail_count++;
                end else begin
                    want = xlat_q.pop_front();
                    if (o_hit !== want.hit) begin
                        $display("%0t: hit expected %0d actual %0d", $time, want.hit, o_hit);
                        o_fail_count++;
                    end
                    if (o_frame_out !== want.frame) begin
                        $display("%0t: frame_out expected %h actual %h",
                                 $time, want.frame, o_frame_out);
                        o_fail_count++;
                    end
                    if (o_evicted !== want.evicted) begin
                        $display("%0t: evicted expected %0d actual %0d",
                                 $time, want.evicted, o_evicted);
                        o_fail_count++;
                    end
                    if (o_slot !== want.slot) begin
                        $display("%0t: slot expected %0d actual %0d", $time, want.slot, o_slot);
                        o_fail_count++;
                    end
                    if (o_hits_total !== want.hits) begin
                        $display("%0t: hits_total expected %0d actual %0d",
                                 $time, want.hits, o_hits_total);
                        o_fail_count++;
                    end
                    if (o_misses_total !== want.misses) begin
                        $display("%0t: misses_total expected %0d actual %0d",
                                 $time, want.misses, o_misses_total);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (start && !busy) xlat_q.push_back(translate(i_op, i_pid, i_page, i_frame));
        end
    end
endmodule

// ----- bench/tagged_tlb_fifo_lru_unit_tb.sv -----
// tagged_tlb_fifo_lru_unit_tb: stimulus and verdict for the tagged tlb
// depends on ttlb_pkg, tagged_tlb_fifo_lru_unit, tagged_tlb_fifo_lru_unit_chk
`timescale 1ns / 100ps

module tagged_tlb_fifo_lru_unit_tb;
    import ttlb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [2:0]            i_op;
    logic [PID_BITS-1:0]   i_pid;
    logic [PAGE_BITS-1:0]  i_page;
    logic [FRAME_BITS-1:0] i_frame;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [7:0]            i_cfg_index;
    logic [31:0]           i_cfg_data;
    logic                  o_valid;
    logic                  o_hit;
    logic [19:0]           o_frame_out;
    logic                  o_evicted;
    logic [3:0]            o_slot;
    logic [31:0]           o_hits_total;
    logic [31:0]           o_misses_total;
    int                    fail_count;
    int                    pending;
    int                    cycles;

    logic [PID_BITS-1:0]   pid_pool  [4];
    logic [PAGE_BITS-1:0]  page_pool [6];

    tagged_tlb_fifo_lru_unit u_dut (.*);

    tagged_tlb_fifo_lru_unit_chk u_chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic [2:0] op, logic [PID_BITS-1:0] pid,
                        logic [PAGE_BITS-1:0] page, logic [FRAME_BITS-1:0] frame);
        int gap;
        gap = pick_gap();
        start <= 1'b1;
        i_op <= op;
        i_pid <= pid;
        i_page <= page;
        i_frame <= frame;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [2:0]            op;
        logic [PID_BITS-1:0]   pid;
        logic [PAGE_BITS-1:0]  page;
        int                    r;
        r = $urandom_range(0, 99);
        if (r < 42) op = OP_LOOKUP;
        else if (r < 72) op = OP_INSERT;
        else if (r < 86) op = OP_DROP;
        else if (r < 92) op = OP_FLUSH_PID;
        else if (r < 95) op = OP_FLUSH_ALL;
        else op = 3'($urandom_range(OP_FLUSH_PID + 1, 7));
        // small tag pools keep hits and duplicates frequent
        pid = ($urandom_range(0, 9) < 8) ? pid_pool[$urandom_range(0, 3)] : PID_BITS'($urandom);
        page = ($urandom_range(0, 9) < 8) ? page_pool[$urandom_range(0, 5)]
                                          : PAGE_BITS'($urandom);
        send(op, pid, page, FRAME_BITS'($urandom));
    endtask

    initial begin
        int sizes[6];
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_op <= OP_LOOKUP;
        i_pid <= '0;
        i_page <= '0;
        i_frame <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        pid_pool = '{16'h0000, 16'hffff, 16'h5a5a, 16'h0001};
        page_pool = '{20'h00000, 20'hfffff, 20'h12345, 20'h00001, 20'h80000, 20'h7ffff};
        sizes = '{1, 16, 0, 31, 17, 5};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, duplicates, misses, drops, flushes, unknown ops
        send(OP_LOOKUP, '0, '0, '0);
        send(OP_INSERT, '0, '0, '1);
        send(OP_INSERT, '1, '1, '0);
        send(OP_INSERT, '1, '1, 20'h5a5a5);
        send(OP_LOOKUP, '1, '1, '0);
        send(OP_LOOKUP, '0, '0, '0);
        send(OP_DROP, 16'h1234, 20'h1, '0);
        send(OP_DROP, '1, '1, '0);
        send(OP_LOOKUP, '1, '1, '0);
        send(OP_FLUSH_PID, '0, '0, '0);
        send(OP_LOOKUP, '0, '0, '0);
        for (int k = OP_FLUSH_PID + 1; k < 8; k++) send(3'(k), '1, '1, '1);
        drain();
        write_reg(8'(REG_POLICY), 32'd1);
        write_reg(8'(REG_SIZE), 32'd2);
        send(OP_INSERT, 16'h1, 20'h1, 20'h11);
        send(OP_INSERT, 16'h2, 20'h2, 20'h22);
        send(OP_LOOKUP, 16'h1, 20'h1, '0);
        send(OP_INSERT, 16'h3, 20'h3, 20'h33);
        send(OP_LOOKUP, 16'h2, 20'h2, '0);
        send(OP_FLUSH_ALL, '0, '0, '0);
        drain();
        write_reg(8'd2, 32'hffff_ffff);
        write_reg(8'hff, 32'd0);
        write_reg(8'(REG_SIZE), 32'd16);
        write_reg(8'(REG_POLICY), 32'd0);

        for (int ph = 0; ph < 6; ph++) begin
            for (int n = 0; n < 170; n++) random_item();
            // sender holds off until every expected result is in
            drain();
            write_reg(8'(REG_POLICY), 32'($urandom_range(0, 1)));
            write_reg(8'(REG_SIZE), 32'(sizes[ph]));
        end

        drain();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
